>>> rtl/hrds_pkg.sv
// ----------------------------------------------------------------------------
// hrds_pkg: shared types and constants for the HID descriptor scanner
// Transaction payloads, table entry layout, item prefixes and status codes.
// ----------------------------------------------------------------------------
package hrds_pkg;

  // Report table depth
  localparam int MAX_REPORTS = 16;
  localparam int IDX_W = (MAX_REPORTS > 1) ? $clog2(MAX_REPORTS) : 1;
  localparam logic [8:0] MAX_CNT = 9'(MAX_REPORTS);

  // Item prefixes with the size bits cleared
  localparam logic [7:0] PFX_USAGE_PAGE = 8'h04;
  localparam logic [7:0] PFX_USAGE      = 8'h08;
  localparam logic [7:0] PFX_REPORT_ID  = 8'h84;
  localparam logic [7:0] PFX_COLLECTION = 8'hA0;

  localparam logic [31:0] COLLECTION_APPLICATION = 32'd1;
  localparam logic [7:0]  COUNT_MAX = 8'hFF;

  // Operation codes
  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_BUSY   = 2'd0;
  localparam logic [1:0] STATUS_DONE   = 2'd1;
  localparam logic [1:0] STATUS_TRUNC  = 2'd2;
  localparam logic [1:0] STATUS_LOOKUP = 2'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] query_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] found_usage_page;
    logic [31:0] found_usage;
    logic [7:0]  report_count;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  rpt_id;
    logic [31:0] upage;
    logic [31:0] usage;
  } entry_t;

endpackage

>>> rtl/hid_report_descriptor_scanner_core.sv
// ----------------------------------------------------------------------------
// hid_report_descriptor_scanner_core: HID report descriptor short item scanner
// Parses descriptor bytes into items, records Report ID entries in a table
// memory and answers lookups by report id.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per accepted cycle (req_valid high, req_stall
//   low). A descriptor byte (op 0) is parsed combinationally and its response
//   appears on rsp in the cycle after acceptance; a new byte may be taken every
//   cycle while the response side keeps up.
//   A lookup (op 1) sweeps the report table through its single read port,
//   one entry per cycle unless rsp stalls: id 0 reads only entry 0, an empty
//   table reads none, other ids up to min(report_count, MAX_REPORTS) entries.
//   req_stall stays high while a lookup sweeps the table.
//   rsp is held in an output register; while rsp_stall is high the pending
//   response holds and req_stall rises, so no transaction is lost.
//   Reset (rst, synchronous) clears the parser, the count, the current page
//   and usage and the table valid bits, and holds req_stall high; a byte with
//   first_byte set clears them the same way in the cycle it is taken, so no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module hid_report_descriptor_scanner_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  hrds_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output hrds_pkg::rsp_t rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  localparam int IW = hrds_pkg::IDX_W;

  logic state;
  logic state_next;

  // Parser state
  logic [31:0] cur_page;
  logic [31:0] cur_usage;
  logic [5:0]  item_tag;
  logic [2:0]  bytes_left;
  logic [1:0]  byte_slot;
  logic [31:0] item_content;
  logic [7:0]  reports_seen;
  logic [hrds_pkg::MAX_REPORTS-1:0] valid;

  // Report table
  hrds_pkg::entry_t mem [hrds_pkg::MAX_REPORTS];
  hrds_pkg::entry_t rd_entry;
  logic             rd_vld;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;

  // Lookup sweep
  logic [7:0]    query;
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] scan_last;
  logic [IW-1:0] scan_idx_next;

  logic out_free;
  logic req_acc;
  logic byte_acc;
  logic look_acc;

  // Effective state after an optional clear
  logic [31:0] e_page;
  logic [31:0] e_usage;
  logic [5:0]  e_tag;
  logic [2:0]  e_left;
  logic [1:0]  e_slot;
  logic [31:0] e_content;
  logic [7:0]  e_rs;

  logic [31:0] page_next;
  logic [31:0] usage_next;
  logic [5:0]  tag_next;
  logic [2:0]  left_next;
  logic [1:0]  slot_next;
  logic [31:0] content_next;
  logic [7:0]  rs_next;
  logic [1:0]  status_next;
  logic [2:0]  size;
  logic        apply;
  logic        wr_en;
  logic [IW-1:0] wr_addr;
  hrds_pkg::entry_t wr_data;
  logic [hrds_pkg::MAX_REPORTS-1:0] valid_next;

  logic [8:0] fill;
  logic [7:0] entry_id;
  logic       hit;
  logic       done;

  logic           res_en;
  hrds_pkg::rsp_t res;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = rst || (state == ST_SCAN) || !out_free;
  assign req_acc   = req_valid && !req_stall;
  assign byte_acc  = req_acc && (req.op == hrds_pkg::OP_BYTE);
  assign look_acc  = req_acc && (req.op == hrds_pkg::OP_LOOKUP);

  // Descriptor byte parsing
  always_comb begin
    e_page    = req.first_byte ? 32'd0 : cur_page;
    e_usage   = req.first_byte ? 32'd0 : cur_usage;
    e_tag     = req.first_byte ? 6'd0  : item_tag;
    e_left    = req.first_byte ? 3'd0  : bytes_left;
    e_slot    = req.first_byte ? 2'd0  : byte_slot;
    e_content = req.first_byte ? 32'd0 : item_content;
    e_rs      = req.first_byte ? 8'd0  : reports_seen;

    size         = 3'd0;
    tag_next     = e_tag;
    left_next    = e_left;
    slot_next    = e_slot;
    content_next = e_content;
    apply        = 1'b0;

    if (e_left == 3'd0) begin
      size         = (req.data_byte[1:0] == 2'd3) ? 3'd4 : {1'b0, req.data_byte[1:0]};
      tag_next     = req.data_byte[7:2];
      content_next = 32'd0;
      slot_next    = 2'd0;
      left_next    = size;
      apply        = (size == 3'd0);
    end else begin
      content_next = e_content | ({24'd0, req.data_byte} << {e_slot, 3'b000});
      slot_next    = e_slot + 2'd1;
      left_next    = e_left - 3'd1;
      apply        = (left_next == 3'd0);
    end

    page_next  = e_page;
    usage_next = e_usage;
    rs_next    = e_rs;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;

    if (apply) begin
      unique case ({tag_next, 2'b00})
        hrds_pkg::PFX_REPORT_ID: begin
          if (e_rs != hrds_pkg::COUNT_MAX && {1'b0, e_rs} < hrds_pkg::MAX_CNT) begin
            wr_en   = 1'b1;
            wr_addr = e_rs[IW-1:0];
            wr_data = '{rpt_id: content_next[7:0], upage: e_page, usage: e_usage};
          end
          if (e_rs != hrds_pkg::COUNT_MAX) begin
            rs_next = e_rs + 8'd1;
          end
        end
        hrds_pkg::PFX_COLLECTION: begin
          // with no report counted, entry 0 still holds id 0
          if (content_next == hrds_pkg::COLLECTION_APPLICATION && e_rs == 8'd0) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '{rpt_id: 8'd0, upage: e_page, usage: e_usage};
          end
        end
        hrds_pkg::PFX_USAGE_PAGE: page_next = content_next;
        hrds_pkg::PFX_USAGE:      usage_next = content_next;
        default: ;
      endcase
    end

    status_next = hrds_pkg::STATUS_BUSY;
    if (req.last_byte) begin
      status_next = (left_next != 3'd0) ? hrds_pkg::STATUS_TRUNC : hrds_pkg::STATUS_DONE;
      left_next   = 3'd0;
      slot_next   = 2'd0;
    end

    valid_next = req.first_byte ? '0 : valid;
    if (wr_en) begin
      valid_next[wr_addr] = 1'b1;
    end
  end

  // Lookup control and response selection
  always_comb begin
    fill = ({1'b0, reports_seen} < hrds_pkg::MAX_CNT) ? {1'b0, reports_seen}
                                                      : hrds_pkg::MAX_CNT;
    // invalid entries read as zero
    entry_id = rd_vld ? rd_entry.rpt_id : 8'd0;
    hit      = (entry_id == query);
    done     = hit || (query == 8'd0) || (scan_idx == scan_last);

    state_next    = state;
    scan_idx_next = scan_idx;
    rd_en         = 1'b0;
    rd_addr       = '0;
    res_en        = 1'b0;
    res           = '{status: hrds_pkg::STATUS_LOOKUP, found: 1'b0, found_usage_page: 32'd0,
                      found_usage: 32'd0, report_count: reports_seen};

    unique case (state)
      ST_IDLE: begin
        if (byte_acc) begin
          res_en = 1'b1;
          res    = '{status: status_next, found: 1'b0, found_usage_page: 32'd0,
                     found_usage: 32'd0, report_count: rs_next};
        end else if (look_acc) begin
          if (req.query_id == 8'd0 || fill != 9'd0) begin
            rd_en         = 1'b1;
            rd_addr       = '0;
            scan_idx_next = '0;
            state_next    = ST_SCAN;
          end else begin
            res_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          if (done) begin
            res_en     = 1'b1;
            state_next = ST_IDLE;
            if (hit) begin
              res.found            = 1'b1;
              res.found_usage_page = rd_vld ? rd_entry.upage : 32'd0;
              res.found_usage      = rd_vld ? rd_entry.usage : 32'd0;
            end
          end else begin
            // advance to the next entry
            scan_idx_next = scan_idx + {{(IW-1){1'b0}}, 1'b1};
            rd_en         = 1'b1;
            rd_addr       = scan_idx_next;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cur_page     <= 32'd0;
      cur_usage    <= 32'd0;
      item_tag     <= 6'd0;
      bytes_left   <= 3'd0;
      byte_slot    <= 2'd0;
      item_content <= 32'd0;
      reports_seen <= 8'd0;
      valid        <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (byte_acc) begin
        cur_page     <= page_next;
        cur_usage    <= usage_next;
        item_tag     <= tag_next;
        bytes_left   <= left_next;
        byte_slot    <= slot_next;
        item_content <= content_next;
        reports_seen <= rs_next;
        valid        <= valid_next;
      end
      if (out_free) begin
        rsp_valid <= res_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (look_acc) begin
      query     <= req.query_id;
      scan_last <= IW'(fill - 9'd1);
    end
    scan_idx <= scan_idx_next;
    if (out_free && res_en) begin
      rsp <= res;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (byte_acc && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
      rd_vld   <= valid[rd_addr];
    end
  end

endmodule

>>> tb/hid_report_descriptor_scanner_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_report_descriptor_scanner_core_test: self-checking bench for the scanner
// Streams HID descriptors and lookups at the core with random gaps and output
// stalls. A behavioral scanner computes each response when its transaction is
// accepted, and the monitor compares responses field by field in order.
// ----------------------------------------------------------------------------
module hid_report_descriptor_scanner_core_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  hrds_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b1;
  hrds_pkg::rsp_t rsp;

  hid_report_descriptor_scanner_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Behavioral scanner state
  // --------------------------------------------------------------------------
  logic [31:0] usage_page_now;
  logic [31:0] usage_now;
  logic [5:0]  tag_now;
  logic [2:0]  data_due;
  logic [1:0]  data_pos;
  logic [31:0] content_acc;
  logic [7:0]  report_total;
  logic [7:0]  tbl_id    [hrds_pkg::MAX_REPORTS];
  logic [31:0] tbl_page  [hrds_pkg::MAX_REPORTS];
  logic [31:0] tbl_usage [hrds_pkg::MAX_REPORTS];

  hrds_pkg::req_t req_backlog [$];
  hrds_pkg::rsp_t rsp_due [$];
  int   mismatches = 0;

  function automatic void clear_scanner();
    usage_page_now = '0;
    usage_now      = '0;
    tag_now        = '0;
    data_due       = '0;
    data_pos       = '0;
    content_acc    = '0;
    report_total   = '0;
    for (int i = 0; i < hrds_pkg::MAX_REPORTS; i++) begin
      tbl_id[i]    = '0;
      tbl_page[i]  = '0;
      tbl_usage[i] = '0;
    end
  endfunction

  function automatic void close_item();
    logic [7:0] pfx;
    pfx = {tag_now, 2'b00};
    if (pfx == hrds_pkg::PFX_REPORT_ID) begin
      // drop the entry once the table is full, keep counting up to saturation
      if (report_total < hrds_pkg::COUNT_MAX &&
          int'(report_total) < hrds_pkg::MAX_REPORTS) begin
        tbl_id[int'(report_total)]    = content_acc[7:0];
        tbl_page[int'(report_total)]  = usage_page_now;
        tbl_usage[int'(report_total)] = usage_now;
      end
      if (report_total < hrds_pkg::COUNT_MAX) report_total = report_total + 8'd1;
    end else if (pfx == hrds_pkg::PFX_COLLECTION) begin
      if (content_acc == hrds_pkg::COLLECTION_APPLICATION && report_total == 8'd0 &&
          tbl_id[0] == 8'd0) begin
        tbl_page[0]  = usage_page_now;
        tbl_usage[0] = usage_now;
      end
    end else if (pfx == hrds_pkg::PFX_USAGE_PAGE) begin
      usage_page_now = content_acc;
    end else if (pfx == hrds_pkg::PFX_USAGE) begin
      usage_now = content_acc;
    end
  endfunction

  function automatic hrds_pkg::rsp_t scan_step(hrds_pkg::req_t r);
    hrds_pkg::rsp_t a;
    int   span;
    a = '0;
    a.status = hrds_pkg::STATUS_BUSY;
    if (r.op == hrds_pkg::OP_LOOKUP) begin
      a.status = hrds_pkg::STATUS_LOOKUP;
      if (r.query_id == 8'd0) begin
        if (tbl_id[0] == 8'd0) begin
          a.found            = 1'b1;
          a.found_usage_page = tbl_page[0];
          a.found_usage      = tbl_usage[0];
        end
      end else begin
        span = (int'(report_total) < hrds_pkg::MAX_REPORTS) ? int'(report_total)
                                                            : hrds_pkg::MAX_REPORTS;
        for (int i = 0; i < span; i++) begin
          if (tbl_id[i] == r.query_id) begin
            a.found            = 1'b1;
            a.found_usage_page = tbl_page[i];
            a.found_usage      = tbl_usage[i];
            break;
          end
        end
      end
    end else begin
      if (r.first_byte) clear_scanner();
      if (data_due == 3'd0) begin
        tag_now     = r.data_byte[7:2];
        content_acc = '0;
        data_pos    = '0;
        data_due    = (r.data_byte[1:0] == 2'd3) ? 3'd4 : {1'b0, r.data_byte[1:0]};
        if (data_due == 3'd0) close_item();
      end else begin
        content_acc = content_acc | (32'(r.data_byte) << (8 * data_pos));
        data_pos    = data_pos + 2'd1;
        data_due    = data_due - 3'd1;
        if (data_due == 3'd0) close_item();
      end
      if (r.last_byte) begin
        a.status = (data_due != 3'd0) ? hrds_pkg::STATUS_TRUNC : hrds_pkg::STATUS_DONE;
        data_due = '0;
        data_pos = '0;
      end
    end
    a.report_count = report_total;
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predict on acceptance, then present the next transaction
  // --------------------------------------------------------------------------
  int send_wait = 0;
  int send_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      clear_scanner();
    end else begin
      if (req_valid && !req_stall) rsp_due.push_back(scan_step(req));
      if (!req_valid || !req_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          req       <= req_backlog.pop_front();
          req_valid <= 1'b1;
          if (send_calm > 0) begin
            send_calm--;
            send_wait = 0;
          end else begin
            send_wait = pick_gap();
            if ($urandom_range(0, 40) == 0) send_calm = $urandom_range(20, 100);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted response with the oldest prediction
  // --------------------------------------------------------------------------
  int   hold_left = 0;
  int   hold_calm = 0;
  hrds_pkg::rsp_t want;

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due.size() == 0) begin
          $display("%0t: response with nothing expected, expected none, actual %h",
                   $time, rsp);
          mismatches++;
        end else begin
          want = rsp_due.pop_front();
          compare_field("status", 32'(want.status), 32'(rsp.status));
          compare_field("found", 32'(want.found), 32'(rsp.found));
          compare_field("found_usage_page", want.found_usage_page, rsp.found_usage_page);
          compare_field("found_usage", want.found_usage, rsp.found_usage);
          compare_field("report_count", 32'(want.report_count), 32'(rsp.report_count));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        if (hold_calm > 0) begin
          hold_calm--;
        end else if ($urandom_range(0, 2) == 0) begin
          hold_left = pick_gap();
          if ($urandom_range(0, 40) == 0) hold_calm = $urandom_range(20, 100);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic [7:0] desc_bytes [$];
  logic [7:0] id_pool [$];

  task automatic add_byte(logic [7:0] b, bit first, bit last);
    hrds_pkg::req_t t;
    t.op         = hrds_pkg::OP_BYTE;
    t.data_byte  = b;
    t.first_byte = first;
    t.last_byte  = last;
    t.query_id   = 8'($urandom_range(0, 255));
    req_backlog.push_back(t);
  endtask

  // flags and data byte are noise on a lookup
  task automatic add_lookup(logic [7:0] id);
    hrds_pkg::req_t t;
    t.op         = hrds_pkg::OP_LOOKUP;
    t.data_byte  = 8'($urandom_range(0, 255));
    t.first_byte = 1'($urandom_range(0, 1));
    t.last_byte  = 1'($urandom_range(0, 1));
    t.query_id   = id;
    req_backlog.push_back(t);
  endtask

  function automatic logic [7:0] pick_query();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5 && id_pool.size() > 0) return id_pool[$urandom_range(0, id_pool.size() - 1)];
    if (r < 7) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  // append a prefix and as many little-endian data bytes as its size asks
  task automatic put_item(logic [7:0] prefix, logic [31:0] value);
    int n;
    n = (prefix[1:0] == 2'd3) ? 4 : int'(prefix[1:0]);
    desc_bytes.push_back(prefix);
    for (int i = 0; i < n; i++) desc_bytes.push_back(value[8*i +: 8]);
  endtask

  task automatic send_desc(bit open_first, bit close_last, int lookup_pct);
    int n;
    n = desc_bytes.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < lookup_pct) add_lookup(pick_query());
      add_byte(desc_bytes[i], open_first && i == 0, close_last && i == n - 1);
    end
    desc_bytes.delete();
  endtask

  task automatic gen_random_desc();
    int         n;
    int         r;
    int         sz;
    logic [7:0] rid;
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 30) : $urandom_range(1, 10);
    for (int k = 0; k < n; k++) begin
      r  = $urandom_range(0, 11);
      sz = $urandom_range(1, 3);
      case (r)
        0, 1: put_item(hrds_pkg::PFX_USAGE_PAGE | 8'(sz), $urandom);
        2, 3: put_item(hrds_pkg::PFX_USAGE | 8'(sz), $urandom);
        4: begin
          if ($urandom_range(0, 3) == 0) begin
            put_item(hrds_pkg::PFX_COLLECTION | 8'(sz), $urandom_range(0, 2));
          end else begin
            put_item(hrds_pkg::PFX_COLLECTION | 8'd1, hrds_pkg::COLLECTION_APPLICATION);
          end
        end
        5, 6, 7: begin
          rid = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 7))
                                            : 8'($urandom_range(0, 255));
          r = $urandom_range(0, 9);
          if (r == 0) begin
            put_item(hrds_pkg::PFX_REPORT_ID, 32'd0);
            rid = 8'd0;
          end else if (r == 1) begin
            put_item(hrds_pkg::PFX_REPORT_ID | 8'(sz),
                     {16'd0, 8'($urandom_range(0, 255)), rid});
          end else begin
            put_item(hrds_pkg::PFX_REPORT_ID | 8'd1, 32'(rid));
          end
          id_pool.push_back(rid);
          if (id_pool.size() > 32) void'(id_pool.pop_front());
        end
        8:  put_item(8'hFE, $urandom);
        9:  put_item({6'($urandom_range(0, 63)), 2'(sz)}, $urandom);
        10: put_item({6'($urandom_range(0, 63)), 2'b00}, 32'd0);
        default: desc_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    r = $urandom_range(0, 9);
    if (r < 2) begin
      // cut the final item short before the descriptor ends
      sz = $urandom_range(1, 3);
      desc_bytes.push_back({6'($urandom_range(0, 63)), 2'(sz)});
      n = $urandom_range(0, (sz == 3) ? 3 : sz - 1);
      for (int i = 0; i < n; i++) desc_bytes.push_back(8'($urandom_range(0, 255)));
      send_desc($urandom_range(0, 9) != 0, 1'b1, 8);
    end else if (r == 2) begin
      if ($urandom_range(0, 1) == 1) desc_bytes.push_back(8'h07);
      send_desc($urandom_range(0, 9) != 0, 1'b0, 8);
    end else begin
      send_desc($urandom_range(0, 9) != 0, 1'b1, 8);
    end
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) add_lookup(pick_query());
  endtask

  // drive the count past the table size and into saturation
  task automatic gen_saturating_desc();
    put_item(hrds_pkg::PFX_USAGE_PAGE | 8'd1, $urandom);
    put_item(hrds_pkg::PFX_USAGE | 8'd2, $urandom);
    for (int i = 0; i < 270; i++) begin
      if (i % 50 == 7) put_item(hrds_pkg::PFX_REPORT_ID | 8'd1, $urandom_range(1, 255));
      else desc_bytes.push_back(hrds_pkg::PFX_REPORT_ID);
    end
    send_desc(1'b1, 1'b1, 2);
    for (int i = 0; i < 4; i++) add_lookup(pick_query());
  endtask

  initial begin
    bit saturated;
    saturated = 1'b0;

    // application collection before any report fills entry 0
    put_item(hrds_pkg::PFX_USAGE_PAGE | 8'd1, 32'h01);
    put_item(hrds_pkg::PFX_USAGE | 8'd1, 32'h06);
    put_item(hrds_pkg::PFX_COLLECTION | 8'd1, hrds_pkg::COLLECTION_APPLICATION);
    send_desc(1'b1, 1'b0, 0);
    add_lookup(8'd0);
    add_lookup(8'hFF);
    // widest data, then a report with the top id
    put_item(hrds_pkg::PFX_USAGE_PAGE | 8'd3, 32'hDEADBEEF);
    put_item(hrds_pkg::PFX_USAGE | 8'd2, 32'h1234);
    put_item(hrds_pkg::PFX_REPORT_ID | 8'd1, 32'hFF);
    send_desc(1'b0, 1'b0, 0);
    add_lookup(8'hFF);
    add_lookup(8'd0);
    // long prefix as a two byte item, then a truncated report id
    put_item(8'hFE, 32'h2211);
    desc_bytes.push_back(hrds_pkg::PFX_REPORT_ID | 8'd1);
    send_desc(1'b0, 1'b1, 0);
    add_lookup(8'hFF);
    // bytes after the end keep parsing; report id with no data stores id 0
    desc_bytes.push_back(8'hC0);
    desc_bytes.push_back(hrds_pkg::PFX_REPORT_ID);
    send_desc(1'b0, 1'b1, 0);
    add_lookup(8'd0);
    add_lookup(8'd0);

    while (req_backlog.size() < 1500) begin
      if (!saturated && req_backlog.size() > 600) begin
        gen_saturating_desc();
        saturated = 1'b1;
      end else begin
        gen_random_desc();
      end
    end

    wait (!rst);
    do @(posedge clk); while (req_backlog.size() > 0 || req_valid || rsp_due.size() > 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && rsp_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
